// ===== rtl/c6809_pkg.sv =====
// ----------------------------------------------------------------------------
// c6809_pkg
// Shared types and codes for the 6809 immediate ALU and branch block.
// ----------------------------------------------------------------------------
package c6809_pkg;

    // Operation codes carried in the kind field.
    localparam logic [5:0] K_NOP   = 6'd0;
    localparam logic [5:0] K_LDA   = 6'd1;
    localparam logic [5:0] K_LDB   = 6'd2;
    localparam logic [5:0] K_LDD   = 6'd3;
    localparam logic [5:0] K_LDX   = 6'd4;
    localparam logic [5:0] K_LDY   = 6'd5;
    localparam logic [5:0] K_LDU   = 6'd6;
    localparam logic [5:0] K_LDS   = 6'd7;
    localparam logic [5:0] K_CMPA  = 6'd8;
    localparam logic [5:0] K_CMPB  = 6'd9;
    localparam logic [5:0] K_CMPD  = 6'd10;
    localparam logic [5:0] K_CMPX  = 6'd11;
    localparam logic [5:0] K_CMPY  = 6'd12;
    localparam logic [5:0] K_ADDA  = 6'd13;
    localparam logic [5:0] K_ADDB  = 6'd14;
    localparam logic [5:0] K_ADDD  = 6'd15;
    localparam logic [5:0] K_SUBA  = 6'd16;
    localparam logic [5:0] K_SUBB  = 6'd17;
    localparam logic [5:0] K_SUBD  = 6'd18;
    localparam logic [5:0] K_ANDA  = 6'd19;
    localparam logic [5:0] K_ANDB  = 6'd20;
    localparam logic [5:0] K_ORA   = 6'd21;
    localparam logic [5:0] K_ORB   = 6'd22;
    localparam logic [5:0] K_EORA  = 6'd23;
    localparam logic [5:0] K_EORB  = 6'd24;
    localparam logic [5:0] K_INCA  = 6'd25;
    localparam logic [5:0] K_INCB  = 6'd26;
    localparam logic [5:0] K_DECA  = 6'd27;
    localparam logic [5:0] K_DECB  = 6'd28;
    localparam logic [5:0] K_TSTA  = 6'd29;
    localparam logic [5:0] K_TSTB  = 6'd30;
    localparam logic [5:0] K_ANDCC = 6'd31;
    localparam logic [5:0] K_ORCC  = 6'd32;
    localparam logic [5:0] K_BRA   = 6'd33;

    // Branch condition codes.
    localparam logic [3:0] BC_ALWAYS = 4'd0;
    localparam logic [3:0] BC_EQ     = 4'd1;
    localparam logic [3:0] BC_NE     = 4'd2;
    localparam logic [3:0] BC_MI     = 4'd3;
    localparam logic [3:0] BC_PL     = 4'd4;
    localparam logic [3:0] BC_CS     = 4'd5;
    localparam logic [3:0] BC_CC     = 4'd6;
    localparam logic [3:0] BC_VS     = 4'd7;
    localparam logic [3:0] BC_VC     = 4'd8;
    localparam logic [3:0] BC_GT     = 4'd9;
    localparam logic [3:0] BC_GE     = 4'd10;
    localparam logic [3:0] BC_LT     = 4'd11;
    localparam logic [3:0] BC_LE     = 4'd12;
    localparam logic [3:0] BC_HI     = 4'd13;
    localparam logic [3:0] BC_LS     = 4'd14;
    localparam logic [3:0] BC_NONE   = 4'd15;

    // Condition code bit positions.
    localparam int CC_C = 0;
    localparam int CC_V = 1;
    localparam int CC_Z = 2;
    localparam int CC_N = 3;
    localparam int CC_H = 5;

    typedef struct packed {
        logic [5:0] kind;
        logic       immediate_mode;
        logic [1:0] operand_count;
        logic [7:0] first_operand_byte;
        logic [7:0] second_operand_byte;
        logic [3:0] branch_condition;
    } c6809_op_t;

    typedef struct packed {
        logic [7:0]  cc;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] u;
        logic [15:0] s;
    } c6809_regs_t;

endpackage

// ===== rtl/c6809_in_stage.sv =====
// ----------------------------------------------------------------------------
// c6809_in_stage
// Input register: captures one request and holds it until execute moves on.
// ----------------------------------------------------------------------------
module c6809_in_stage
    import c6809_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  c6809_op_t req_op,
    input  logic      advance,
    output logic      op_valid,
    output c6809_op_t op
);

    logic      valid_reg;
    c6809_op_t op_reg;

    // The slot frees up in the same cycle that its request moves to the result.
    assign req_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            op_reg <= req_op;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

// ===== rtl/c6809_alu.sv =====
// ----------------------------------------------------------------------------
// c6809_alu
// Execute logic: next register file, flags and branch decision for one request.
// ----------------------------------------------------------------------------
module c6809_alu
    import c6809_pkg::*;
(
    input  c6809_op_t   op,
    input  c6809_regs_t cur,
    output c6809_regs_t nxt,
    output logic        taken
);

    logic [5:0]  kind_eff;
    logic [7:0]  op8;
    logic [15:0] op16;
    logic [15:0] d;
    logic        use_b;
    logic [7:0]  acc8;
    logic [8:0]  sub8;
    logic [8:0]  add8;
    logic [4:0]  half;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  and8;
    logic [7:0]  or8;
    logic [7:0]  eor8;
    logic        sub8_v;
    logic        add8_v;
    logic [15:0] w16;
    logic [16:0] sub16;
    logic [16:0] add16;
    logic        sub16_v;
    logic        add16_v;
    logic        fc;
    logic        fv;
    logic        fz;
    logic        fn;

    function automatic logic [7:0] nzv8(input logic [7:0] cc, input logic [7:0] v);
        logic [7:0] r;
        r       = cc;
        r[CC_N] = v[7];
        r[CC_Z] = (v == 8'h00);
        r[CC_V] = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] nzv16(input logic [7:0] cc, input logic [15:0] v);
        logic [7:0] r;
        r       = cc;
        r[CC_N] = v[15];
        r[CC_Z] = (v == 16'h0000);
        r[CC_V] = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        op8  = (op.operand_count != 2'd0) ? op.first_operand_byte : 8'h00;
        op16 = op.operand_count[1] ? {op.first_operand_byte, op.second_operand_byte}
                                   : 16'h0000;
        d    = {cur.a, cur.b};

        // Memory-mode loads and ALU operations are dropped to a no-op.
        if (op.kind >= K_LDA && op.kind <= K_EORB && !op.immediate_mode)
        begin
            kind_eff = K_NOP;
        end
        else
        begin
            kind_eff = op.kind;
        end

        use_b = (kind_eff == K_CMPB) || (kind_eff == K_ADDB) || (kind_eff == K_SUBB) ||
                (kind_eff == K_ANDB) || (kind_eff == K_ORB)  || (kind_eff == K_EORB) ||
                (kind_eff == K_INCB) || (kind_eff == K_DECB) || (kind_eff == K_TSTB);
        acc8  = use_b ? cur.b : cur.a;

        sub8   = {1'b0, acc8} - {1'b0, op8};
        add8   = {1'b0, acc8} + {1'b0, op8};
        half   = {1'b0, acc8[3:0]} + {1'b0, op8[3:0]};
        inc8   = acc8 + 8'd1;
        dec8   = acc8 - 8'd1;
        and8   = acc8 & op8;
        or8    = acc8 | op8;
        eor8   = acc8 ^ op8;
        sub8_v = (acc8[7] ^ op8[7]) & (acc8[7] ^ sub8[7]);
        add8_v = (acc8[7] ^ add8[7]) & (op8[7] ^ add8[7]);

        if (kind_eff == K_CMPX)
        begin
            w16 = cur.x;
        end
        else if (kind_eff == K_CMPY)
        begin
            w16 = cur.y;
        end
        else
        begin
            w16 = d;
        end
        sub16   = {1'b0, w16} - {1'b0, op16};
        add16   = {1'b0, d} + {1'b0, op16};
        sub16_v = (w16[15] ^ op16[15]) & (w16[15] ^ sub16[15]);
        add16_v = (d[15] ^ add16[15]) & (op16[15] ^ add16[15]);

        fc = cur.cc[CC_C];
        fv = cur.cc[CC_V];
        fz = cur.cc[CC_Z];
        fn = cur.cc[CC_N];

        nxt   = cur;
        taken = 1'b0;

        unique case (kind_eff)
            K_LDA:
            begin
                nxt.a  = op8;
                nxt.cc = nzv8(cur.cc, op8);
            end
            K_LDB:
            begin
                nxt.b  = op8;
                nxt.cc = nzv8(cur.cc, op8);
            end
            K_LDD:
            begin
                {nxt.a, nxt.b} = op16;
                nxt.cc         = nzv16(cur.cc, op16);
            end
            K_LDX:
            begin
                nxt.x  = op16;
                nxt.cc = nzv16(cur.cc, op16);
            end
            K_LDY:
            begin
                nxt.y  = op16;
                nxt.cc = nzv16(cur.cc, op16);
            end
            K_LDU:
            begin
                nxt.u  = op16;
                nxt.cc = nzv16(cur.cc, op16);
            end
            K_LDS:
            begin
                nxt.s  = op16;
                nxt.cc = nzv16(cur.cc, op16);
            end
            K_CMPA, K_CMPB, K_SUBA, K_SUBB:
            begin
                nxt.cc       = nzv8(cur.cc, sub8[7:0]);
                nxt.cc[CC_V] = sub8_v;
                nxt.cc[CC_C] = sub8[8];
                if (kind_eff == K_SUBA)
                begin
                    nxt.a = sub8[7:0];
                end
                else if (kind_eff == K_SUBB)
                begin
                    nxt.b = sub8[7:0];
                end
            end
            K_CMPD, K_CMPX, K_CMPY, K_SUBD:
            begin
                nxt.cc       = nzv16(cur.cc, sub16[15:0]);
                nxt.cc[CC_V] = sub16_v;
                nxt.cc[CC_C] = sub16[16];
                if (kind_eff == K_SUBD)
                begin
                    {nxt.a, nxt.b} = sub16[15:0];
                end
            end
            K_ADDA, K_ADDB:
            begin
                nxt.cc       = nzv8(cur.cc, add8[7:0]);
                nxt.cc[CC_V] = add8_v;
                nxt.cc[CC_C] = add8[8];
                nxt.cc[CC_H] = half[4];
                if (kind_eff == K_ADDA)
                begin
                    nxt.a = add8[7:0];
                end
                else
                begin
                    nxt.b = add8[7:0];
                end
            end
            K_ADDD:
            begin
                nxt.cc         = nzv16(cur.cc, add16[15:0]);
                nxt.cc[CC_V]   = add16_v;
                nxt.cc[CC_C]   = add16[16];
                {nxt.a, nxt.b} = add16[15:0];
            end
            K_ANDA:
            begin
                nxt.a  = and8;
                nxt.cc = nzv8(cur.cc, and8);
            end
            K_ANDB:
            begin
                nxt.b  = and8;
                nxt.cc = nzv8(cur.cc, and8);
            end
            K_ORA:
            begin
                nxt.a  = or8;
                nxt.cc = nzv8(cur.cc, or8);
            end
            K_ORB:
            begin
                nxt.b  = or8;
                nxt.cc = nzv8(cur.cc, or8);
            end
            K_EORA:
            begin
                nxt.a  = eor8;
                nxt.cc = nzv8(cur.cc, eor8);
            end
            K_EORB:
            begin
                nxt.b  = eor8;
                nxt.cc = nzv8(cur.cc, eor8);
            end
            K_INCA, K_INCB:
            begin
                nxt.cc       = nzv8(cur.cc, inc8);
                nxt.cc[CC_V] = (inc8 == 8'h80);
                if (kind_eff == K_INCA)
                begin
                    nxt.a = inc8;
                end
                else
                begin
                    nxt.b = inc8;
                end
            end
            K_DECA, K_DECB:
            begin
                nxt.cc       = nzv8(cur.cc, dec8);
                nxt.cc[CC_V] = (dec8 == 8'h7F);
                if (kind_eff == K_DECA)
                begin
                    nxt.a = dec8;
                end
                else
                begin
                    nxt.b = dec8;
                end
            end
            K_TSTA, K_TSTB:
            begin
                nxt.cc = nzv8(cur.cc, acc8);
            end
            K_ANDCC:
            begin
                nxt.cc = cur.cc & op8;
            end
            K_ORCC:
            begin
                nxt.cc = cur.cc | op8;
            end
            K_BRA:
            begin
                unique case (op.branch_condition)
                    BC_ALWAYS: taken = 1'b1;
                    BC_EQ:     taken = fz;
                    BC_NE:     taken = !fz;
                    BC_MI:     taken = fn;
                    BC_PL:     taken = !fn;
                    BC_CS:     taken = fc;
                    BC_CC:     taken = !fc;
                    BC_VS:     taken = fv;
                    BC_VC:     taken = !fv;
                    BC_GT:     taken = !fz && (fn == fv);
                    BC_GE:     taken = (fn == fv);
                    BC_LT:     taken = (fn != fv);
                    BC_LE:     taken = fz || (fn != fv);
                    BC_HI:     taken = !fc && !fz;
                    BC_LS:     taken = fc || fz;
                    BC_NONE:   taken = 1'b0;
                endcase
            end
            default:
            begin
                nxt   = cur;
                taken = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/cpu6809_immediate_alu_and_branch.sv =====
// ----------------------------------------------------------------------------
// cpu6809_immediate_alu_and_branch
// 6809 register file with immediate loads, ALU operations and branch tests.
// ----------------------------------------------------------------------------
// An accepted request is held in the input register and moves into the register
// file, which doubles as the result register, once the result slot is free.
// Throughput: one request per cycle while the result side does not stall, set by
// the single execute pass between the input register and the register file.
// Reset clears the register file, the condition codes and both valid flags.
module cpu6809_immediate_alu_and_branch
    import c6809_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [5:0]  kind,
    input  logic        immediate_mode,
    input  logic [1:0]  operand_count,
    input  logic [7:0]  first_operand_byte,
    input  logic [7:0]  second_operand_byte,
    input  logic [3:0]  branch_condition,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  condition_codes,
    output logic [7:0]  accumulator_a,
    output logic [7:0]  accumulator_b,
    output logic [15:0] index_x,
    output logic [15:0] index_y,
    output logic [15:0] user_stack,
    output logic [15:0] system_stack,
    output logic        branch_taken
);

    c6809_op_t   req_op;
    c6809_op_t   op;
    logic        op_valid;
    logic        advance;
    c6809_regs_t regs_reg;
    c6809_regs_t regs_next;
    logic        taken_next;
    logic        taken_reg;
    logic        res_valid_reg;

    assign req_op.kind                = kind;
    assign req_op.immediate_mode      = immediate_mode;
    assign req_op.operand_count       = operand_count;
    assign req_op.first_operand_byte  = first_operand_byte;
    assign req_op.second_operand_byte = second_operand_byte;
    assign req_op.branch_condition    = branch_condition;

    // The register file only changes when the result slot is free, so it can
    // be shown directly as the result while a response is stalled.
    assign advance = !res_valid_reg || res_ready;

    c6809_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_op   (req_op),
        .advance  (advance),
        .op_valid (op_valid),
        .op       (op)
    );

    c6809_alu u_alu
    (
        .op   (op),
        .cur  (regs_reg),
        .nxt  (regs_next),
        .taken(taken_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg      <= '0;
            taken_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= op_valid;
            if (op_valid)
            begin
                regs_reg  <= regs_next;
                taken_reg <= taken_next;
            end
        end
    end

    assign res_valid       = res_valid_reg;
    assign condition_codes = regs_reg.cc;
    assign accumulator_a   = regs_reg.a;
    assign accumulator_b   = regs_reg.b;
    assign index_x         = regs_reg.x;
    assign index_y         = regs_reg.y;
    assign user_stack      = regs_reg.u;
    assign system_stack    = regs_reg.s;
    assign branch_taken    = taken_reg;

endmodule

// ===== bench/cpu6809_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu6809_result_checker
// Predicts and checks every result of the 6809 immediate ALU and branch block.
// ----------------------------------------------------------------------------
// Watches the request and result handshakes. Each accepted request runs
// through a private copy of the register file and condition codes. The
// registers and branch decision that follow are queued and compared, field by
// field, with the next accepted result.
module cpu6809_result_checker
    import c6809_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [5:0]  kind,
    input  logic        immediate_mode,
    input  logic [1:0]  operand_count,
    input  logic [7:0]  first_operand_byte,
    input  logic [7:0]  second_operand_byte,
    input  logic [3:0]  branch_condition,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [7:0]  condition_codes,
    input  logic [7:0]  accumulator_a,
    input  logic [7:0]  accumulator_b,
    input  logic [15:0] index_x,
    input  logic [15:0] index_y,
    input  logic [15:0] user_stack,
    input  logic [15:0] system_stack,
    input  logic        branch_taken,
    output int          failures,
    output int          outstanding,
    output int          checked
);

    typedef struct packed {
        c6809_regs_t regs;
        logic        taken;
    } c6809_result_t;

    c6809_regs_t   arch;
    c6809_result_t expected_results_q[$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
        checked     = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h expected %h",
                                      checked, name, got, want));
    endtask

    // Value moves set N and Z and clear V; carry is left alone.
    function automatic logic [7:0] moved8(input logic [7:0] v);
        arch.cc[CC_N] = v[7];
        arch.cc[CC_Z] = (v == 8'h00);
        arch.cc[CC_V] = 1'b0;
        return v;
    endfunction

    function automatic logic [15:0] moved16(input logic [15:0] v);
        arch.cc[CC_N] = v[15];
        arch.cc[CC_Z] = (v == 16'h0000);
        arch.cc[CC_V] = 1'b0;
        return v;
    endfunction

    // INC and DEC flag overflow only when the result lands on the given value.
    function automatic logic [7:0] stepped8(input logic [7:0] v, input logic [7:0] ovf);
        arch.cc[CC_N] = v[7];
        arch.cc[CC_Z] = (v == 8'h00);
        arch.cc[CC_V] = (v == ovf);
        return v;
    endfunction

    function automatic logic [7:0] diff8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] t;
        r = a - b;
        t = (a ^ b) & (a ^ r);
        arch.cc[CC_C] = (a < b);
        arch.cc[CC_V] = t[7];
        arch.cc[CC_N] = r[7];
        arch.cc[CC_Z] = (r == 8'h00);
        return r;
    endfunction

    function automatic logic [15:0] diff16(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] r;
        logic [15:0] t;
        r = a - b;
        t = (a ^ b) & (a ^ r);
        arch.cc[CC_C] = (a < b);
        arch.cc[CC_V] = t[15];
        arch.cc[CC_N] = r[15];
        arch.cc[CC_Z] = (r == 16'h0000);
        return r;
    endfunction

    // Apart from ANDCC and ORCC, the 8-bit adds are the only operations that write the half carry.
    function automatic logic [7:0] sum8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        logic [4:0] half;
        logic [7:0] t;
        s    = {1'b0, a} + {1'b0, b};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        t    = (a ^ s[7:0]) & (b ^ s[7:0]);
        arch.cc[CC_H] = half[4];
        arch.cc[CC_C] = s[8];
        arch.cc[CC_V] = t[7];
        arch.cc[CC_N] = s[7];
        arch.cc[CC_Z] = (s[7:0] == 8'h00);
        return s[7:0];
    endfunction

    function automatic logic condition_met(input logic [3:0] cond, input logic [7:0] cc);
        logic c;
        logic v;
        logic z;
        logic n;
        c = cc[CC_C];
        v = cc[CC_V];
        z = cc[CC_Z];
        n = cc[CC_N];
        case (cond)
            BC_ALWAYS: return 1'b1;
            BC_EQ:     return z;
            BC_NE:     return !z;
            BC_MI:     return n;
            BC_PL:     return !n;
            BC_CS:     return c;
            BC_CC:     return !c;
            BC_VS:     return v;
            BC_VC:     return !v;
            BC_GT:     return !z && (n == v);
            BC_GE:     return n == v;
            BC_LT:     return n != v;
            BC_LE:     return z || (n != v);
            BC_HI:     return !c && !z;
            BC_LS:     return c || z;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic execute_op(input c6809_op_t op, output logic taken);
        logic [5:0]  k;
        logic [7:0]  op8;
        logic [15:0] op16;
        logic [15:0] d;
        logic [16:0] wide;
        logic [15:0] t16;
        k     = op.kind;
        taken = 1'b0;
        op8   = (op.operand_count != 2'd0) ? op.first_operand_byte : 8'h00;
        op16  = op.operand_count[1] ? {op.first_operand_byte, op.second_operand_byte}
                                    : 16'h0000;
        d     = {arch.a, arch.b};
        // Loads and ALU operations outside immediate mode change nothing.
        if (k >= K_LDA && k <= K_EORB && !op.immediate_mode)
            k = K_NOP;
        case (k)
            K_LDA:   arch.a = moved8(op8);
            K_LDB:   arch.b = moved8(op8);
            K_LDD:   {arch.a, arch.b} = moved16(op16);
            K_LDX:   arch.x = moved16(op16);
            K_LDY:   arch.y = moved16(op16);
            K_LDU:   arch.u = moved16(op16);
            K_LDS:   arch.s = moved16(op16);
            K_CMPA:  void'(diff8(arch.a, op8));
            K_CMPB:  void'(diff8(arch.b, op8));
            K_CMPD:  void'(diff16(d, op16));
            K_CMPX:  void'(diff16(arch.x, op16));
            K_CMPY:  void'(diff16(arch.y, op16));
            K_ADDA:  arch.a = sum8(arch.a, op8);
            K_ADDB:  arch.b = sum8(arch.b, op8);
            K_ADDD:
            begin
                wide = {1'b0, d} + {1'b0, op16};
                t16  = (d ^ wide[15:0]) & (op16 ^ wide[15:0]);
                arch.cc[CC_C] = wide[16];
                arch.cc[CC_V] = t16[15];
                arch.cc[CC_N] = wide[15];
                arch.cc[CC_Z] = (wide[15:0] == 16'h0000);
                {arch.a, arch.b} = wide[15:0];
            end
            K_SUBA:  arch.a = diff8(arch.a, op8);
            K_SUBB:  arch.b = diff8(arch.b, op8);
            K_SUBD:  {arch.a, arch.b} = diff16(d, op16);
            K_ANDA:  arch.a = moved8(arch.a & op8);
            K_ANDB:  arch.b = moved8(arch.b & op8);
            K_ORA:   arch.a = moved8(arch.a | op8);
            K_ORB:   arch.b = moved8(arch.b | op8);
            K_EORA:  arch.a = moved8(arch.a ^ op8);
            K_EORB:  arch.b = moved8(arch.b ^ op8);
            K_INCA:  arch.a = stepped8(arch.a + 8'd1, 8'h80);
            K_INCB:  arch.b = stepped8(arch.b + 8'd1, 8'h80);
            K_DECA:  arch.a = stepped8(arch.a - 8'd1, 8'h7F);
            K_DECB:  arch.b = stepped8(arch.b - 8'd1, 8'h7F);
            K_TSTA:  void'(moved8(arch.a));
            K_TSTB:  void'(moved8(arch.b));
            K_ANDCC: arch.cc = arch.cc & op8;
            K_ORCC:  arch.cc = arch.cc | op8;
            K_BRA:   taken = condition_met(op.branch_condition, arch.cc);
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        c6809_op_t     op;
        c6809_result_t want;
        logic          taken;
        if (!rst_n)
        begin
            arch = '0;
            expected_results_q.delete();
            outstanding = 0;
        end
        else
        begin
            // A result always belongs to an older request, so it is checked first.
            if (res_valid && res_ready)
            begin
                if (expected_results_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no request waiting",
                                              checked));
                else
                begin
                    want = expected_results_q.pop_front();
                    check_field("condition_codes", 16'(condition_codes),
                                16'(want.regs.cc));
                    check_field("accumulator_a", 16'(accumulator_a), 16'(want.regs.a));
                    check_field("accumulator_b", 16'(accumulator_b), 16'(want.regs.b));
                    check_field("index_x", index_x, want.regs.x);
                    check_field("index_y", index_y, want.regs.y);
                    check_field("user_stack", user_stack, want.regs.u);
                    check_field("system_stack", system_stack, want.regs.s);
                    check_field("branch_taken", 16'(branch_taken), 16'(want.taken));
                end
                checked++;
            end
            if (req_valid && req_ready)
            begin
                op.kind                = kind;
                op.immediate_mode      = immediate_mode;
                op.operand_count       = operand_count;
                op.first_operand_byte  = first_operand_byte;
                op.second_operand_byte = second_operand_byte;
                op.branch_condition    = branch_condition;
                execute_op(op, taken);
                want.regs  = arch;
                want.taken = taken;
                expected_results_q.push_back(want);
            end
            outstanding = expected_results_q.size();
        end
    end

endmodule

// ===== bench/cpu6809_immediate_alu_and_branch_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu6809_immediate_alu_and_branch_tb
// Regression bench for the 6809 immediate ALU and branch block.
// ----------------------------------------------------------------------------
// Drives a short directed sequence of edge operands and then random
// operations, mostly immediate-mode work with branch tests mixed in, plus
// ignored and malformed requests. Both handshakes idle under three profiles,
// and the result side holds off twice for a long stretch. The checker
// instance predicts and compares every result.
module cpu6809_immediate_alu_and_branch_tb;
    import c6809_pkg::*;

    localparam int ITEM_COUNT   = 1800;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [5:0]  kind = '0;
    logic        immediate_mode = 1'b0;
    logic [1:0]  operand_count = '0;
    logic [7:0]  first_operand_byte = '0;
    logic [7:0]  second_operand_byte = '0;
    logic [3:0]  branch_condition = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [7:0]  condition_codes;
    logic [7:0]  accumulator_a;
    logic [7:0]  accumulator_b;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [15:0] user_stack;
    logic [15:0] system_stack;
    logic        branch_taken;

    int failures;
    int outstanding;
    int checked;
    int send_idle_pct = 6;
    int recv_idle_pct = 59;
    int sent_count = 0;
    int effective_count = 0;
    int hold_left = 0;
    int hold_stage = 0;
    int cycle_count = 0;

    cpu6809_immediate_alu_and_branch uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_ready           (req_ready),
        .kind                (kind),
        .immediate_mode      (immediate_mode),
        .operand_count       (operand_count),
        .first_operand_byte  (first_operand_byte),
        .second_operand_byte (second_operand_byte),
        .branch_condition    (branch_condition),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .condition_codes     (condition_codes),
        .accumulator_a       (accumulator_a),
        .accumulator_b       (accumulator_b),
        .index_x             (index_x),
        .index_y             (index_y),
        .user_stack          (user_stack),
        .system_stack        (system_stack),
        .branch_taken        (branch_taken)
    );

    cpu6809_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_ready           (req_ready),
        .kind                (kind),
        .immediate_mode      (immediate_mode),
        .operand_count       (operand_count),
        .first_operand_byte  (first_operand_byte),
        .second_operand_byte (second_operand_byte),
        .branch_condition    (branch_condition),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .condition_codes     (condition_codes),
        .accumulator_a       (accumulator_a),
        .accumulator_b       (accumulator_b),
        .index_x             (index_x),
        .index_y             (index_y),
        .user_stack          (user_stack),
        .system_stack        (system_stack),
        .branch_taken        (branch_taken),
        .failures            (failures),
        .outstanding         (outstanding),
        .checked             (checked)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random back-pressure, plus two long hold-offs while the
    // sender keeps offering requests so that the pipeline fills.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if ((hold_stage == 0 && sent_count >= 300) ||
                (hold_stage == 1 && sent_count >= 1500))
            begin
                hold_stage++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic c6809_op_t make_op(input logic [5:0] k, input logic imm,
                                          input logic [1:0] cnt, input logic [7:0] hi,
                                          input logic [7:0] lo, input logic [3:0] cond);
        c6809_op_t op;
        op.kind                = k;
        op.immediate_mode      = imm;
        op.operand_count       = cnt;
        op.first_operand_byte  = hi;
        op.second_operand_byte = lo;
        op.branch_condition    = cond;
        return op;
    endfunction

    // Operands lean toward the boundaries where carries and overflows flip.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_op(output c6809_op_t op, output bit effective);
        int  roll;
        bit  wide_op;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            op = make_op(6'($urandom), 1'($urandom), 2'($urandom), pick_byte(),
                         pick_byte(), 4'($urandom));
        end
        else
        begin
            op.kind = (roll < 27) ? K_BRA : 6'($urandom_range(K_LDA, K_ORCC));
            wide_op = (op.kind >= K_LDD && op.kind <= K_LDS) ||
                      (op.kind >= K_CMPD && op.kind <= K_CMPY) ||
                      op.kind == K_ADDD || op.kind == K_SUBD;
            op.immediate_mode      = ($urandom_range(19) != 0);
            op.operand_count       = ($urandom_range(9) < 8) ? (wide_op ? 2'd2 : 2'd1)
                                                             : 2'($urandom);
            op.first_operand_byte  = pick_byte();
            op.second_operand_byte = pick_byte();
            op.branch_condition    = 4'($urandom);
        end
        effective = !(op.kind == K_NOP || op.kind > K_BRA ||
                      (op.kind <= K_EORB && !op.immediate_mode));
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input c6809_op_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid           <= 1'b1;
        kind                <= op.kind;
        immediate_mode      <= op.immediate_mode;
        operand_count       <= op.operand_count;
        first_operand_byte  <= op.first_operand_byte;
        second_operand_byte <= op.second_operand_byte;
        branch_condition    <= op.branch_condition;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        c6809_op_t directed_q[$];
        c6809_op_t op;
        bit        effective;
        int        wait_cycles;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Loads of edge values, including missing operand bytes.
        directed_q.push_back(make_op(K_LDA, 1'b1, 2'd1, 8'h80, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_LDB, 1'b1, 2'd0, 8'hAA, 8'h55, BC_ALWAYS));
        directed_q.push_back(make_op(K_LDD, 1'b1, 2'd3, 8'h7F, 8'hFF, BC_ALWAYS));
        directed_q.push_back(make_op(K_LDX, 1'b1, 2'd2, 8'hFF, 8'hFF, BC_ALWAYS));
        directed_q.push_back(make_op(K_LDY, 1'b1, 2'd2, 8'h80, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_LDU, 1'b1, 2'd1, 8'h55, 8'hAA, BC_ALWAYS));
        directed_q.push_back(make_op(K_LDS, 1'b1, 2'd2, 8'h12, 8'h34, BC_ALWAYS));
        // A load outside immediate mode must leave everything alone.
        directed_q.push_back(make_op(K_LDA, 1'b0, 2'd1, 8'h33, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_ADDA, 1'b1, 2'd1, 8'h7F, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_ADDB, 1'b1, 2'd1, 8'h01, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_ADDD, 1'b1, 2'd2, 8'hFF, 8'hFF, BC_ALWAYS));
        directed_q.push_back(make_op(K_SUBA, 1'b1, 2'd1, 8'h80, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_SUBB, 1'b1, 2'd1, 8'hFF, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_SUBD, 1'b1, 2'd2, 8'h80, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_CMPA, 1'b1, 2'd1, 8'hFF, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_CMPX, 1'b1, 2'd2, 8'hFF, 8'hFF, BC_ALWAYS));
        // INC, DEC and TST run whatever the mode says.
        directed_q.push_back(make_op(K_INCA, 1'b0, 2'd0, 8'h00, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_DECB, 1'b0, 2'd0, 8'h00, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_TSTA, 1'b1, 2'd0, 8'h00, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_ORCC, 1'b0, 2'd1, 8'hFF, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_BRA, 1'b1, 2'd0, 8'h00, 8'h00, BC_NONE));
        directed_q.push_back(make_op(K_ANDCC, 1'b1, 2'd1, 8'h00, 8'h00, BC_ALWAYS));
        directed_q.push_back(make_op(K_BRA, 1'b0, 2'd0, 8'h00, 8'h00, BC_HI));
        directed_q.push_back(make_op(6'h3F, 1'b1, 2'd3, 8'hFF, 8'hFF, BC_NONE));
        foreach (directed_q[i])
            send_op(directed_q[i]);

        while (sent_count < ITEM_COUNT)
        begin
            if (sent_count >= 2 * ITEM_COUNT / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sent_count >= ITEM_COUNT / 3)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 6;
            end
            random_op(op, effective);
            send_op(op);
            if (effective)
                effective_count++;
        end
        req_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        // The pipeline has two stages: give any stray result time to show up.
        wait_cycles = 0;
        while (wait_cycles < 6)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Sent %0d requests (%0d random ones with an effect) under three idling",
                 sent_count, effective_count);
        $display("profiles and two long result stalls; %0d results checked.", checked);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
